// ===== rtl/ffha_pkg.sv =====
package ffha_pkg;

	// Result status codes.
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NOMEM   = 3'd1;
	localparam logic [2:0] ST_ZERO    = 3'd2;
	localparam logic [2:0] ST_BADADDR = 3'd3;
	localparam logic [2:0] ST_DOUBLE  = 3'd4;

	// Request modes.
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_BYTES      = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPLIT_BYTES = 4'd1;
	localparam int CFG_DATA_W = 21;

	// Reset values of the configuration registers.
	localparam logic [20:0] POOL_BYTES_RESET      = 21'd4096;
	localparam logic [12:0] MIN_SPLIT_BYTES_RESET = 13'd32;

	// Request and result payloads.
	typedef struct packed {
		logic        mode;
		logic [19:0] request_bytes;
		logic [19:0] data_offset;
	} req_t;

	typedef struct packed {
		logic [19:0] granted_offset;
		logic [2:0]  status;
	} rsp_t;

	// Controller states.
	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_SCAN,
		S_ALLOC_FIX,
		S_ALLOC_TAIL,
		S_FREE_NEXT,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic ready;
		logic init;
		logic start;
		logic scan;
		logic alloc_fix;
		logic alloc_tail;
		logic free_next;
		logic shift_rd;
		logic shift_wr;
		logic load_out;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic reinit;
		logic trivial;
		logic found;
		logic hit_free;
		logic last;
		logic split;
		logic up_shift;
		logic k_zero;
		logic dn_shift;
		logic shift_last;
		logic dir_up;
		logic out_free;
	} dp_sts_t;

endpackage

// ===== rtl/ffha_ram.sv =====
module ffha_ram import ffha_pkg::*; #(
	parameter int WIDTH = 21,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/ffha_ctrl.sv =====
module ffha_ctrl import ffha_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  dp_sts_t  sts,
	output ctl_cmd_t cmd
);

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT: state_d = S_IDLE;
			S_IDLE: begin
				if (req_valid) begin
					state_d = sts.trivial ? S_DONE : S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.found) begin
					if (sts.dir_up) begin
						state_d = S_ALLOC_FIX;
					end else if (sts.hit_free) begin
						state_d = S_DONE;
					end else begin
						state_d = S_FREE_NEXT;
					end
				end else if (sts.last) begin
					state_d = S_DONE;
				end
			end
			S_ALLOC_FIX: begin
				if (!sts.split) begin
					state_d = S_DONE;
				end else if (sts.up_shift) begin
					state_d = S_SHIFT_RD;
				end else begin
					state_d = S_ALLOC_TAIL;
				end
			end
			S_ALLOC_TAIL: state_d = S_DONE;
			S_FREE_NEXT: begin
				if (!sts.k_zero && sts.dn_shift) begin
					state_d = S_SHIFT_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SHIFT_RD: state_d = S_SHIFT_WR;
			S_SHIFT_WR: begin
				if (sts.shift_last) begin
					state_d = sts.dir_up ? S_ALLOC_TAIL : S_DONE;
				end else begin
					state_d = S_SHIFT_RD;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_INIT;
		endcase
		// A pool size write rebuilds the table.
		if (sts.reinit) begin
			state_d = S_INIT;
		end
	end

	// Commands.
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_INIT: cmd.init = 1'b1;
			S_IDLE: begin
				cmd.ready = 1'b1;
				cmd.start = req_valid;
			end
			S_SCAN:       cmd.scan       = 1'b1;
			S_ALLOC_FIX:  cmd.alloc_fix  = 1'b1;
			S_ALLOC_TAIL: cmd.alloc_tail = 1'b1;
			S_FREE_NEXT:  cmd.free_next  = 1'b1;
			S_SHIFT_RD:   cmd.shift_rd   = 1'b1;
			S_SHIFT_WR:   cmd.shift_wr   = 1'b1;
			S_DONE:       cmd.load_out   = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== rtl/ffha_datapath.sv =====
module ffha_datapath import ffha_pkg::*; #(
	parameter int MAX_BLOCKS     = 64,
	parameter int HEADER_BYTES   = 16,
	parameter int POOL_ADDR_BITS = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  req_t                  req,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  rsp_ready,
	output logic                  rsp_valid,
	output rsp_t                  rsp,
	input  ctl_cmd_t              cmd,
	output dp_sts_t               sts
);

	localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int SW = POOL_ADDR_BITS;
	localparam int EW = SW + 1;
	localparam int AW = ((POOL_ADDR_BITS > 20) ? POOL_ADDR_BITS : 20) + 2;

	localparam logic [AW-1:0] HDR = AW'(HEADER_BYTES);
	localparam logic [AW-1:0] LIM = AW'(1) << SW;

	// Configuration registers.
	logic [20:0] pool_q;
	logic [12:0] min_split_q;

	// Walk and bookkeeping registers.
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] idx_q, hit_q, src_q, dst_q, end_q;
	logic [AW-1:0] hdr_q, need_q, off_q, prev_span_q, rest_q, sum_q;
	logic [SW-1:0] hit_size_q;
	logic [19:0]   granted_q;
	logic [2:0]    status_q;
	logic          mode_q, prev_free_q, mp_q, has_next_q, dir_up_q, out_valid_q;
	rsp_t          rsp_q;

	// Table memory port signals.
	logic          wr_en, rd_en;
	logic [IW-1:0] wr_addr, rd_addr;
	logic [EW-1:0] wr_data, rd_data;

	logic [SW-1:0] rd_size;
	logic          rd_free;
	logic [AW-1:0] size_ext, cap, size0, diff, newsize;
	logic          fit, match, last, split, mn;
	logic [1:0]    k;
	logic [IW-1:0] base;
	logic [CW:0]   dn_src;

	ffha_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Entry decode and per-step arithmetic.
	always_comb begin
		rd_size  = rd_data[SW-1:0];
		rd_free  = rd_data[SW];
		size_ext = AW'(rd_size);
		fit      = rd_free && (size_ext >= need_q);
		diff     = size_ext - need_q;
		match    = (hdr_q + HDR) == off_q;
		last     = (CW'(idx_q) == (cnt_q - CW'(1)));
		cap      = (AW'(pool_q) > LIM) ? LIM : AW'(pool_q);
		size0    = (cap >= HDR) ? (cap - HDR) : '0;
		split    = (rest_q >= (HDR + AW'(min_split_q))) && (cnt_q < CW'(MAX_BLOCKS));
		mn       = has_next_q && rd_free;
		k        = {1'b0, mp_q} + {1'b0, mn};
		base     = mp_q ? (hit_q - IW'(1)) : hit_q;
		newsize  = sum_q + (mn ? (HDR + size_ext) : '0);
		dn_src   = (CW+1)'(base) + (CW+1)'(1) + (CW+1)'(k);
	end

	// Status toward the controller.
	always_comb begin
		sts            = '0;
		sts.reinit     = cfg_valid && (cfg_index == CFG_POOL_BYTES);
		sts.trivial    = (req.mode == MODE_FREE) ? (req.data_offset == '0)
		                                         : (req.request_bytes == '0);
		sts.found      = (mode_q == MODE_FREE) ? match : fit;
		sts.hit_free   = rd_free;
		sts.last       = last;
		sts.split      = split;
		sts.up_shift   = ((CW+1)'(hit_q) + (CW+1)'(2)) <= (CW+1)'(cnt_q);
		sts.k_zero     = (k == 2'd0);
		sts.dn_shift   = (dn_src + (CW+1)'(1)) <= (CW+1)'(cnt_q);
		sts.shift_last = (src_q == end_q);
		sts.dir_up     = (mode_q == MODE_ALLOC);
		sts.out_free   = !out_valid_q || rsp_ready;
	end

	// Memory port selection.
	always_comb begin
		rd_en   = cmd.start || cmd.scan || cmd.shift_rd;
		rd_addr = cmd.shift_rd ? src_q : (cmd.scan ? (idx_q + IW'(1)) : '0);
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		if (cmd.init) begin
			wr_en   = 1'b1;
			wr_data = {1'b1, size0[SW-1:0]};
		end else if (cmd.alloc_fix) begin
			wr_en   = 1'b1;
			wr_addr = hit_q;
			wr_data = {1'b0, split ? need_q[SW-1:0] : hit_size_q};
		end else if (cmd.alloc_tail) begin
			wr_en   = 1'b1;
			wr_addr = hit_q + IW'(1);
			wr_data = {1'b1, SW'(rest_q - HDR)};
		end else if (cmd.free_next) begin
			wr_en   = 1'b1;
			wr_addr = base;
			wr_data = {1'b1, newsize[SW-1:0]};
		end else if (cmd.shift_wr) begin
			wr_en   = 1'b1;
			wr_addr = dst_q;
			wr_data = rd_data;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q      <= POOL_BYTES_RESET;
			min_split_q <= MIN_SPLIT_BYTES_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_POOL_BYTES) begin
				pool_q <= cfg_data;
			end else if (cfg_index == CFG_MIN_SPLIT_BYTES) begin
				min_split_q <= cfg_data[12:0];
			end
		end
	end

	// Block count and output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= CW'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.init) begin
				cnt_q <= CW'(1);
			end else if (cmd.alloc_tail) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.free_next) begin
				cnt_q <= cnt_q - CW'(k);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Walk registers.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mode_q      <= req.mode;
			need_q      <= (AW'(req.request_bytes) + AW'(7)) & ~AW'(7);
			off_q       <= AW'(req.data_offset);
			hdr_q       <= '0;
			idx_q       <= '0;
			prev_free_q <= 1'b0;
			granted_q   <= '0;
			status_q    <= ((req.mode == MODE_ALLOC) && (req.request_bytes == '0))
			               ? ST_ZERO : ST_OK;
		end
		if (cmd.scan) begin
			hdr_q       <= hdr_q + HDR + size_ext;
			prev_free_q <= rd_free;
			prev_span_q <= HDR + size_ext;
			idx_q       <= idx_q + IW'(1);
			hit_q       <= idx_q;
			hit_size_q  <= rd_size;
			rest_q      <= diff;
			mp_q        <= prev_free_q;
			sum_q       <= size_ext + (prev_free_q ? prev_span_q : '0);
			has_next_q  <= (CW'(idx_q) + CW'(1)) < cnt_q;
			if (sts.found) begin
				if (mode_q == MODE_ALLOC) begin
					granted_q <= hdr_q[19:0] + HDR[19:0];
					status_q  <= ST_OK;
				end else begin
					status_q  <= rd_free ? ST_DOUBLE : ST_OK;
				end
			end else if (last) begin
				status_q <= (mode_q == MODE_FREE) ? ST_BADADDR : ST_NOMEM;
			end
		end
		// Shift setup: up for a split, down after a merge.
		if (cmd.alloc_fix) begin
			dir_up_q <= 1'b1;
			src_q    <= IW'(cnt_q - CW'(1));
			dst_q    <= IW'(cnt_q);
			end_q    <= hit_q + IW'(1);
		end
		if (cmd.free_next) begin
			dir_up_q <= 1'b0;
			src_q    <= IW'(dn_src);
			dst_q    <= base + IW'(1);
			end_q    <= IW'(cnt_q - CW'(1));
		end
		if (cmd.shift_wr) begin
			src_q <= dir_up_q ? (src_q - IW'(1)) : (src_q + IW'(1));
			dst_q <= dir_up_q ? (dst_q - IW'(1)) : (dst_q + IW'(1));
		end
		if (cmd.load_out) begin
			rsp_q.granted_offset <= granted_q;
			rsp_q.status         <= status_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

	// The table always holds between one and MAX_BLOCKS blocks.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q >= CW'(1)) && (cnt_q <= CW'(MAX_BLOCKS)))
		else $error("block count out of range");

	// A shift never writes past the end of the table.
	a_shift_dst: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_wr |-> (CW'(dst_q) <= cnt_q))
		else $error("shift writes beyond the table");

	// A loaded result is presented on the next cycle.
	a_load_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("result not presented after load");

	// A split only happens while the table has room.
	a_split_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc_tail |-> (cnt_q < CW'(MAX_BLOCKS)))
		else $error("split with a full table");

endmodule

// ===== rtl/first_fit_heap_allocator_unit.sv =====
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  req_t: mode, request_bytes, data_offset
// rsp      out        rsp_valid / rsp_ready  rsp_t: granted_offset, status
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A request walks the block table one entry per cycle, up to the last block.
// A split or a merge then moves the following entries through the single table memory,
// each one read in S_SHIFT_RD and written in S_SHIFT_WR.
// Zero-size allocates and null frees skip the table walk.
// After reset and after each pool_bytes write, the init state rebuilds entry 0 before
// requests are taken. A stalled result waits in the output register.
module first_fit_heap_allocator_unit import ffha_pkg::*; #(
	parameter int MAX_BLOCKS     = 64,
	parameter int HEADER_BYTES   = 16,
	parameter int POOL_ADDR_BITS = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output rsp_t                  rsp,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	// Sequencer for the table walk and shifts.
	ffha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Table, arithmetic and result register.
	ffha_datapath #(
		.MAX_BLOCKS     (MAX_BLOCKS),
		.HEADER_BYTES   (HEADER_BYTES),
		.POOL_ADDR_BITS (POOL_ADDR_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_ready (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

	assign req_ready = cmd.ready;
	assign cfg_ready = 1'b1;

endmodule

// ===== verif/ffha_checker.sv =====
module ffha_checker import ffha_pkg::*; #(
	parameter int MAX_BLOCKS     = 64,
	parameter int HEADER_BYTES   = 16,
	parameter int POOL_ADDR_BITS = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  logic                  req_ready,
	input  req_t                  req,
	input  logic                  rsp_valid,
	input  logic                  rsp_ready,
	input  rsp_t                  rsp,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    errors,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Shadow copy of the block table and the configuration.
	longint heap_pool_bytes;
	longint split_floor;
	longint blk_size [MAX_BLOCKS];
	bit     blk_free [MAX_BLOCKS];
	int     blk_count;
	rsp_t   expected_rsps [$];

	// Rebuild the table as one free block spanning the pool.
	function automatic void rebuild_table();
		longint pool;
		pool = heap_pool_bytes;
		if (pool > (longint'(1) << POOL_ADDR_BITS))
			pool = longint'(1) << POOL_ADDR_BITS;
		for (int k = 0; k < MAX_BLOCKS; k++) begin
			blk_size[k] = 0;
			blk_free[k] = 0;
		end
		blk_size[0] = (pool >= HEADER_BYTES) ? pool - HEADER_BYTES : 0;
		blk_free[0] = 1;
		blk_count = 1;
	endfunction

	// Merge every run of adjacent free blocks.
	function automatic void coalesce_free();
		int k;
		k = 0;
		while (k + 1 < blk_count) begin
			if (blk_free[k] && blk_free[k+1]) begin
				blk_size[k] += HEADER_BYTES + blk_size[k+1];
				for (int j = k + 1; j + 1 < blk_count; j++) begin
					blk_size[j] = blk_size[j+1];
					blk_free[j] = blk_free[j+1];
				end
				blk_count--;
				blk_size[blk_count] = 0;
				blk_free[blk_count] = 0;
			end else begin
				k++;
			end
		end
	endfunction

	// Work out the result of one request and update the shadow table.
	function automatic rsp_t allocate_or_free(req_t r);
		rsp_t   res;
		longint need, rest, hdr, off;
		bit     done;
		res.granted_offset = '0;
		res.status = ST_OK;
		hdr = 0;
		done = 0;
		if (r.mode == MODE_ALLOC) begin
			if (r.request_bytes == 0) begin
				res.status = ST_ZERO;
			end else begin
				need = (longint'(r.request_bytes) + 7) & ~longint'(7);
				for (int k = 0; k < blk_count && !done; k++) begin
					if (blk_free[k] && blk_size[k] >= need) begin
						rest = blk_size[k] - need;
						if (rest >= HEADER_BYTES + split_floor && blk_count < MAX_BLOCKS) begin
							for (int j = blk_count; j > k + 1; j--) begin
								blk_size[j] = blk_size[j-1];
								blk_free[j] = blk_free[j-1];
							end
							blk_size[k+1] = rest - HEADER_BYTES;
							blk_free[k+1] = 1;
							blk_size[k] = need;
							blk_count++;
						end
						blk_free[k] = 0;
						res.granted_offset = 20'(hdr + HEADER_BYTES);
						done = 1;
					end else begin
						hdr += HEADER_BYTES + blk_size[k];
					end
				end
				if (!done)
					res.status = ST_NOMEM;
			end
		end else if (r.data_offset != 0) begin
			off = r.data_offset;
			for (int k = 0; k < blk_count && !done; k++) begin
				if (hdr + HEADER_BYTES == off) begin
					if (blk_free[k]) begin
						res.status = ST_DOUBLE;
					end else begin
						blk_free[k] = 1;
						coalesce_free();
					end
					done = 1;
				end else begin
					hdr += HEADER_BYTES + blk_size[k];
				end
			end
			if (!done)
				res.status = ST_BADADDR;
		end
		return res;
	endfunction

	// Track configuration, predict each request and compare each result.
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			heap_pool_bytes = POOL_BYTES_RESET;
			split_floor = MIN_SPLIT_BYTES_RESET;
			rebuild_table();
			expected_rsps.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_POOL_BYTES) begin
					heap_pool_bytes = cfg_data;
					rebuild_table();
				end else if (cfg_index == CFG_MIN_SPLIT_BYTES) begin
					split_floor = cfg_data[12:0];
				end
			end
			if (req_valid && req_ready)
				expected_rsps.push_back(allocate_or_free(req));
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					$error("unexpected result transaction: granted_offset %0d status %0d",
						rsp.granted_offset, rsp.status);
					errors++;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.granted_offset !== want.granted_offset) begin
						$error("granted_offset: expected %0d, actual %0d",
							want.granted_offset, rsp.granted_offset);
						errors++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, rsp.status);
						errors++;
					end
				end
			end
		end
		pending = expected_rsps.size();
	end

endmodule

// ===== verif/tb_first_fit_heap_allocator_unit.sv =====
module tb_first_fit_heap_allocator_unit import ffha_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 4'd15;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 250;

	logic                  clk = 0;
	logic                  arst_n = 0;
	logic                  req_valid = 0;
	logic                  req_ready;
	req_t                  req = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 0;
	rsp_t                  rsp;
	logic                  cfg_valid = 0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    errors;
	int                    pending;

	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;
	logic [19:0] live_offsets [$];
	logic [19:0] freed_offsets [$];

	first_fit_heap_allocator_unit dut (.*);

	ffha_checker u_checker (.*);

	always #5 clk = ~clk;

	// Receiver stalls at random at the current rate.
	always @(negedge clk)
		rsp_ready <= ($urandom_range(99) >= stall_pct);

	// Remember granted offsets so that later frees can name real blocks.
	always @(posedge clk)
		if (rsp_valid && rsp_ready && rsp.status == ST_OK && rsp.granted_offset != 0)
			live_offsets.push_back(rsp.granted_offset);

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Send one request; entered and left at a falling edge.
	task automatic send_request(logic m, logic [19:0] nbytes, logic [19:0] off);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 0;
			@(negedge clk);
		end
		req <= '{mode: m, request_bytes: nbytes, data_offset: off};
		req_valid <= 1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Let every outstanding result drain, then give the block time to settle.
	task automatic drain_results();
		req_valid <= 0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 0;
		@(negedge clk);
	endtask

	// Mostly well-formed allocate and free traffic, with some noise.
	task automatic random_request();
		int pick, k;
		logic [19:0] nbytes, off;
		pick = $urandom_range(99);
		nbytes = 20'($urandom);
		off = 20'($urandom);
		if (pick < 40 && live_offsets.size() != 0) begin
			k = $urandom_range(live_offsets.size() - 1);
			off = live_offsets[k];
			live_offsets.delete(k);
			freed_offsets.push_back(off);
			send_request(MODE_FREE, nbytes, off);
		end else if (pick < 75) begin
			if ($urandom_range(9) == 0)
				nbytes = 20'($urandom_range(1, 1048575));
			else
				nbytes = 20'($urandom_range(1, 256));
			send_request(MODE_ALLOC, nbytes, off);
		end else if (pick < 82 && freed_offsets.size() != 0) begin
			send_request(MODE_FREE, nbytes, freed_offsets[$urandom_range(freed_offsets.size() - 1)]);
		end else if (pick < 86) begin
			send_request(MODE_ALLOC, 20'd0, off);
		end else if (pick < 90) begin
			send_request(MODE_FREE, nbytes, 20'd0);
		end else begin
			send_request(MODE_FREE, nbytes, off);
		end
	endtask

	task automatic run_phase(logic [20:0] pool, logic [12:0] min_split, int ip, int sp, int n);
		write_register(CFG_POOL_BYTES, pool);
		write_register(CFG_MIN_SPLIT_BYTES, 21'(min_split));
		live_offsets.delete();
		freed_offsets.delete();
		idle_pct = ip;
		stall_pct = sp;
		for (int i = 0; i < n; i++) begin
			random_request();
			if (i == n / 2 && ($urandom_range(1) == 0))
				drain_results();
		end
		drain_results();
	endtask

	// Stimulus.
	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// Directed part on the reset configuration.
		send_request(MODE_ALLOC, 20'd0, 20'hFFFFF);
		send_request(MODE_ALLOC, 20'hFFFFF, 20'hFFFFF);
		send_request(MODE_ALLOC, 20'd1, 20'hFFFFF);
		send_request(MODE_ALLOC, 20'd9, 20'hFFFFF);
		send_request(MODE_FREE, 20'hFFFFF, 20'd0);
		send_request(MODE_FREE, 20'hFFFFF, 20'd24);
		send_request(MODE_FREE, 20'hFFFFF, 20'hFFFFF);
		send_request(MODE_FREE, 20'hFFFFF, 20'd40);
		send_request(MODE_FREE, 20'hFFFFF, 20'd40);
		send_request(MODE_FREE, 20'hFFFFF, 20'd16);
		send_request(MODE_ALLOC, 20'd4080, 20'hFFFFF);
		send_request(MODE_ALLOC, 20'd8, 20'd0);
		send_request(MODE_FREE, 20'd0, 20'd16);
		send_request(MODE_ALLOC, 20'd4064, 20'd0);
		send_request(MODE_FREE, 20'd0, 20'd16);
		send_request(MODE_ALLOC, 20'd4032, 20'd0);
		send_request(MODE_ALLOC, 20'd48, 20'd0);
		send_request(MODE_FREE, 20'd0, 20'd16);
		send_request(MODE_FREE, 20'd0, 20'd4064);
		drain_results();

		// An unknown register index must leave everything alone.
		write_register(CFG_UNUSED_IDX, 21'h1FFFFF);

		// Random phases over several configurations and idling patterns.
		run_phase(21'd1048576, 13'd8, 0, 0, 110);
		run_phase(21'd64, 13'd0, 71, 0, 40);
		run_phase(21'h1FFFFF, 13'h1FFF, 0, 71, 90);
		run_phase(21'd4096, 13'd32, 6, 6, 120);
		run_phase(21'd0, 13'd4096, 71, 71, 20);
		run_phase(21'd600, 13'd16, 0, 0, 80);
		run_phase(21'd2000, 13'd8, 6, 6, 60);

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
